FILE: rtl/uniform_cubic_spline_eval_assert.svh
// Assertion macros shared by the spline evaluator modules.
// Each macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef UNIFORM_CUBIC_SPLINE_EVAL_ASSERT_SVH
`define UNIFORM_CUBIC_SPLINE_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ucse_pkg.sv
package ucse_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int TERMS        = 4;
    localparam int FRAC_BITS    = 20;

    localparam int SEG_W     = $clog2(MAX_SEGMENTS);
    localparam int SEGF_W    = 6;
    localparam int TERM_W    = $clog2(TERMS);
    localparam int WORD_W    = 32;
    localparam int SPACING_W = 31;
    localparam int POS_W     = WORD_W + 1;
    localparam int PROD_W    = WORD_W + SPACING_W;
    localparam int RAW_W     = PROD_W - 2 * FRAC_BITS;
    localparam int SP_W      = SEG_W + SPACING_W;
    localparam int OFFS_W    = SP_W + 3;
    localparam int ADD_W     = WORD_W + 2;
    localparam int SUM_W     = 2 * WORD_W - FRAC_BITS + 1;
    localparam int CFG_IDX_W = 2;

    localparam int TERM_CUBIC = 0;
    localparam int TERM_QUAD  = 1;
    localparam int TERM_LIN   = 2;
    localparam int TERM_CONST = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [2*WORD_W-1:0] ROUND_BIAS = (2*WORD_W)'(1) << (FRAC_BITS - 1);

    localparam logic [SPACING_W-1:0] SPACING_RESET     = SPACING_W'(1048576);
    localparam logic [SPACING_W-1:0] INV_SPACING_RESET = SPACING_W'(1048576);

    typedef enum logic {
        ACT_LOAD,
        ACT_EVAL
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Z_ORIGIN,
        CFG_SPACING,
        CFG_INV_SPACING,
        CFG_LAST_SEGMENT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [WORD_W-1:0]    z_origin;
        logic        [SPACING_W-1:0] spacing;
        logic        [SPACING_W-1:0] inv_spacing;
        logic        [SEGF_W-1:0]    last_segment;
    } t_cfg;

    typedef struct packed {
        t_action                  action;
        logic                     seg_ok;
        logic [SEG_W-1:0]         seg;
        logic [TERM_W-1:0]        term;
        logic signed [WORD_W-1:0] coef;
        logic signed [POS_W-1:0]  d;
    } t_loc;

    typedef struct packed {
        logic [SEG_W-1:0]               seg;
        logic signed [WORD_W-1:0]       dx;
        logic [TERMS-1:0][WORD_W-1:0]   c;
    } t_eval;

    function automatic t_word sat_word(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-WORD_W:0] hi;
        hi = v[SUM_W-1:WORD_W-1];
        if (hi == '0 || hi == '1) begin
            return v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    function automatic t_word horner_add(input logic signed [2*WORD_W-1:0] prod,
                                         input logic signed [ADD_W-1:0] addend);
        logic signed [2*WORD_W-1:0] biased;
        logic signed [SUM_W-1:0]    sum;
        biased = prod + $signed(ROUND_BIAS);
        sum    = SUM_W'(biased >>> FRAC_BITS) + SUM_W'(addend);
        return sat_word(sum);
    endfunction

endpackage

FILE: rtl/ucse_if.sv
interface ucse_in_if import ucse_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [SEGF_W-1:0]        segment_index;
    logic [TERM_W-1:0]        term_index;
    logic signed [WORD_W-1:0] coefficient;
    logic signed [WORD_W-1:0] z_position;

    modport source (
        output valid, action, segment_index, term_index, coefficient, z_position,
        input  ready
    );
    modport sink (
        input  valid, action, segment_index, term_index, coefficient, z_position,
        output ready
    );
endinterface

interface ucse_out_if import ucse_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] slope;
    logic [SEGF_W-1:0]        segment_used;

    modport source (
        output valid, value, slope, segment_used,
        input  ready
    );
    modport sink (
        input  valid, value, slope, segment_used,
        output ready
    );
endinterface

FILE: rtl/uniform_cubic_spline_eval.sv
// Uniform-grid cubic spline evaluator.
// Items arrive on i_in and carry an action. A load item writes one coefficient
// of one segment into the table and gives no result. An evaluate item gives one
// result on o_out: the value and first derivative at z_position and the clamped
// segment used. Results leave in the order the items were accepted.
// Both channels use valid and ready; an item moves at a rising edge where both are high.
// The configuration port writes one register per cycle while i_cfg_we is high,
// and the user must see that it is only written while no evaluation is in flight;
// the block itself does not enforce this.
// Throughput is one item per cycle while o_out.ready is high: each stage holds
// one item and advances whenever the stage after it is free, so the three-step
// Horner chain of multiply and round stages sets the depth but not the rate.
// When the receiver holds ready low, the output register keeps its item and the
// stages behind it fill up before i_in.ready falls; nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and restores the registers
// to origin 0, spacing 1.0, inverse spacing 1.0 and last segment 0.
// The coefficient table is not cleared and must be loaded before use.
module uniform_cubic_spline_eval import ucse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WORD_W-1:0]     i_cfg_data,
    ucse_in_if.sink               i_in,
    ucse_out_if.source            o_out
);

    t_cfg  r_cfg;
    logic  loc_valid, loc_ready;
    t_loc  loc_item;
    logic  ev_valid, ev_ready;
    t_eval ev_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.z_origin     <= '0;
            r_cfg.spacing      <= SPACING_RESET;
            r_cfg.inv_spacing  <= INV_SPACING_RESET;
            r_cfg.last_segment <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_Z_ORIGIN: begin
                    r_cfg.z_origin <= i_cfg_data;
                end
                CFG_SPACING: begin
                    r_cfg.spacing <= i_cfg_data[SPACING_W-1:0];
                end
                CFG_INV_SPACING: begin
                    r_cfg.inv_spacing <= i_cfg_data[SPACING_W-1:0];
                end
                CFG_LAST_SEGMENT: begin
                    r_cfg.last_segment <= i_cfg_data[SEGF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ucse_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (loc_valid),
        .i_ready (loc_ready),
        .o_item  (loc_item)
    );

    ucse_coef_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (loc_valid),
        .o_ready (loc_ready),
        .i_item  (loc_item),
        .o_valid (ev_valid),
        .i_ready (ev_ready),
        .o_item  (ev_item)
    );

    ucse_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ev_valid),
        .o_ready (ev_ready),
        .i_item  (ev_item),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/ucse_locate.sv
`include "uniform_cubic_spline_eval_assert.svh"

module ucse_locate import ucse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    ucse_in_if.sink   i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_loc      o_item
);

    logic             r_va, r_vb, r_vc;
    t_loc             r_a, r_b, r_c;
    logic [RAW_W-1:0] r_raw;
    t_loc             n_a, n_c;
    logic [RAW_W-1:0] n_raw;
    logic             en_a, en_b, en_c;
    logic [WORD_W-1:0] pos_d;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  lim_last, lim_max, lim, seg_clamp;

    assign en_c       = !r_vc || i_ready;
    assign en_b       = !r_vb || en_c;
    assign en_a       = !r_va || en_b;
    assign i_in.ready = en_a;
    assign o_valid    = r_vc;
    assign o_item     = r_c;

    always_comb begin
        n_a        = '0;
        n_a.action = t_action'(i_in.action);
        n_a.seg_ok = (32'(i_in.segment_index) < 32'(MAX_SEGMENTS));
        n_a.seg    = SEG_W'(i_in.segment_index);
        n_a.term   = i_in.term_index;
        n_a.coef   = i_in.coefficient;
        n_a.d      = POS_W'($signed(i_in.z_position)) - POS_W'($signed(i_cfg.z_origin));
    end

    always_comb begin
        pos_d = (!r_a.d[POS_W-1] && r_a.d != '0) ? WORD_W'(r_a.d) : '0;
        prod  = PROD_W'(pos_d) * PROD_W'(i_cfg.inv_spacing);
        n_raw = prod[PROD_W-1 -: RAW_W];
    end

    always_comb begin
        lim_last  = RAW_W'(i_cfg.last_segment);
        lim_max   = RAW_W'(MAX_SEGMENTS - 1);
        lim       = (lim_last < lim_max) ? lim_last : lim_max;
        seg_clamp = (r_raw > lim) ? lim : r_raw;
        n_c       = r_b;
        if (r_b.action == ACT_EVAL) begin
            n_c.seg = SEG_W'(seg_clamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_in.valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a <= n_a;
        end
        if (en_b) begin
            r_b   <= r_a;
            r_raw <= n_raw;
        end
        if (en_c) begin
            r_c <= n_c;
        end
    end

    `UCSE_ASSERT_NEXT(a_zero_raw_seg, (en_c && r_vb && r_b.action == ACT_EVAL && r_raw == '0), (r_c.seg == '0), "zero raw segment did not map to segment zero")

endmodule

FILE: rtl/ucse_coef_store.sv
`include "uniform_cubic_spline_eval_assert.svh"

module ucse_coef_store import ucse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_loc  i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_eval o_item
);

    logic                     r_vm, r_vx;
    logic [WORD_W-1:0]        r_coef [TERMS];
    logic [SP_W-1:0]          r_m_sp;
    logic signed [POS_W-1:0]  r_m_d;
    logic [SEG_W-1:0]         r_m_seg;
    t_eval                    r_x;
    t_eval                    n_x;
    logic                     en_m, en_x;
    logic                     wr_en, rd_en;
    logic signed [OFFS_W-1:0] diff;

    assign en_x    = !r_vx || i_ready;
    assign en_m    = !r_vm || en_x;
    assign o_ready = en_m;
    assign o_valid = r_vx;
    assign o_item  = r_x;
    assign wr_en   = en_m && i_valid && i_item.action == ACT_LOAD && i_item.seg_ok;
    assign rd_en   = en_m && i_valid && i_item.action == ACT_EVAL;

    for (genvar g = 0; g < TERMS; g++) begin : g_term
        logic [WORD_W-1:0] r_mem [MAX_SEGMENTS];

        always_ff @(posedge i_clk) begin
            if (wr_en && i_item.term == TERM_W'(g)) begin
                r_mem[i_item.seg] <= i_item.coef;
            end
            if (rd_en) begin
                r_coef[g] <= r_mem[i_item.seg];
            end
        end
    end

    always_comb begin
        diff    = OFFS_W'(r_m_d) - OFFS_W'($signed({1'b0, r_m_sp}));
        n_x.seg = r_m_seg;
        n_x.dx  = sat_word(SUM_W'(diff));
        for (int t = 0; t < TERMS; t++) begin
            n_x.c[t] = r_coef[t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vx <= 1'b0;
        end else begin
            if (en_m) begin
                r_vm <= i_valid && i_item.action == ACT_EVAL;
            end
            if (en_x) begin
                r_vx <= r_vm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_m_sp  <= SP_W'(i_item.seg) * SP_W'(i_cfg.spacing);
            r_m_d   <= i_item.d;
            r_m_seg <= i_item.seg;
        end
        if (en_x) begin
            r_x <= n_x;
        end
    end

    `UCSE_ASSERT_NEXT(a_load_no_result, (en_m && i_valid && i_item.action == ACT_LOAD), (!r_vm), "a load item reached the offset stage")

endmodule

FILE: rtl/ucse_horner.sv
`include "uniform_cubic_spline_eval_assert.svh"

module ucse_horner import ucse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_eval       i_item,
    ucse_out_if.source  o_out
);

    logic [6:1]                  r_v;
    logic [6:1]                  en;
    t_eval                       r_e1, r_e2, r_e3, r_e4, r_e5;
    logic signed [2*WORD_W-1:0]  r_p1, r_p3v, r_p3s, r_p5v, r_p5s;
    t_word                       r_s1, r_s2, r_a2, r_a4v, r_a4s;
    t_word                       r_value, r_slope;
    logic [SEG_W-1:0]            r_seg;
    logic signed [SUM_W-1:0]     c0_ext;
    logic signed [ADD_W-1:0]     c1_twice;

    always_comb begin
        en[6] = !r_v[6] || o_out.ready;
        for (int k = 5; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready            = en[1];
    assign o_out.valid        = r_v[6];
    assign o_out.value        = r_value;
    assign o_out.slope        = r_slope;
    assign o_out.segment_used = SEGF_W'(r_seg);

    assign c0_ext   = SUM_W'($signed(i_item.c[TERM_CUBIC]));
    assign c1_twice = ADD_W'($signed(r_e3.c[TERM_QUAD])) <<< 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_e1 <= i_item;
            r_p1 <= $signed(i_item.c[TERM_CUBIC]) * $signed(i_item.dx);
            r_s1 <= sat_word(c0_ext + c0_ext + c0_ext);
        end
        if (en[2]) begin
            r_e2 <= r_e1;
            r_a2 <= horner_add(r_p1, ADD_W'($signed(r_e1.c[TERM_QUAD])));
            r_s2 <= r_s1;
        end
        if (en[3]) begin
            r_e3  <= r_e2;
            r_p3v <= r_a2 * r_e2.dx;
            r_p3s <= r_s2 * r_e2.dx;
        end
        if (en[4]) begin
            r_e4  <= r_e3;
            r_a4v <= horner_add(r_p3v, ADD_W'($signed(r_e3.c[TERM_LIN])));
            r_a4s <= horner_add(r_p3s, c1_twice);
        end
        if (en[5]) begin
            r_e5  <= r_e4;
            r_p5v <= r_a4v * r_e4.dx;
            r_p5s <= r_a4s * r_e4.dx;
        end
        if (en[6]) begin
            r_value <= horner_add(r_p5v, ADD_W'($signed(r_e5.c[TERM_CONST])));
            r_slope <= horner_add(r_p5s, ADD_W'($signed(r_e5.c[TERM_LIN])));
            r_seg   <= r_e5.seg;
        end
    end

    `UCSE_ASSERT_NEXT(a_last_stage_fill, (r_v[5] && en[6]), (r_v[6]), "item lost between the last two stages")
    `UCSE_ASSERT_NEXT(a_first_stage_hold, (r_v[1] && !en[2]), (r_v[1] && $stable(r_p1)), "stalled first stage changed")

endmodule
